// File: hw/rtl/tpb_pkg.sv
// Package for the tempo phasor bank: shared constants, op codes, register indices, increment divider types.
// No dependencies.
package tpb_pkg;
  localparam int MaxPhasors = 16;
  localparam int IdxW = $clog2(MaxPhasors);
  localparam int CntW = $clog2(MaxPhasors + 1);

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_LOCAL_TRIG = 2'd1,
    OP_GLOBAL_RST = 2'd2,
    OP_SET_COUNT = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    REG_TEMPO = 3'd0,
    REG_MULT = 3'd1,
    REG_DIV = 3'd2,
    REG_TICK = 3'd3,
    REG_OFFSET = 3'd4,
    REG_LOOP = 3'd5,
    REG_MULTI = 3'd6
  } reg_t;

  // Control to the increment divider and its status back
  typedef struct packed {
    logic start;
    logic [19:0] tempo;
    logic [31:0] mult;
    logic [31:0] div;
    logic [29:0] tick;
  } inc_req_t;

  typedef struct packed {
    logic done;
    logic big;
    logic [31:0] frac;
  } inc_rsp_t;
endpackage

// File: hw/rtl/tpb_inc_div.sv
// Increment unit: numerator and denominator products, then restoring division one bit a cycle.
// Depends on tpb_pkg.
module tpb_inc_div (
  input  logic            clk,
  input  logic            rst_n,
  input  tpb_pkg::inc_req_t req,
  output tpb_pkg::inc_rsp_t rsp
);
  typedef enum logic [2:0] {S_IDLE, S_MUL1, S_MUL2, S_MUL3, S_DIV} st_t;

  st_t st_r;
  logic [6:0] bit_r;
  logic [51:0] np_r;     // tempo * mult
  logic [65:0] nk_r;     // times k (1 or 10000)
  logic [29:0] tk_r;     // tick, zero taken as one
  logic [67:0] den_r;
  logic [97:0] num_r;    // nk << 32, shifted out MSB first
  logic [68:0] rem_r;
  logic [31:0] q_r;      // quotient low 32 bits
  logic big_r;
  logic done_r;
  logic zero_div_r;

  logic [68:0] trial;
  logic [68:0] shifted;

  assign shifted = {rem_r[67:0], num_r[97]};
  assign trial = shifted - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (st_r)
        S_IDLE: begin
          if (req.start) begin
            zero_div_r <= (req.div == 32'd0);
            np_r <= 52'(req.tempo) * 52'(req.mult);
            tk_r <= (req.tick == 30'd0) ? 30'd1 : req.tick;
            st_r <= S_MUL1;
          end
        end
        S_MUL1: begin
          nk_r <= zero_div_r ? 66'(np_r) * 66'd10000 : 66'(np_r);
          st_r <= S_MUL2;
        end
        S_MUL2: begin
          den_r <= 68'(tk_r) * 68'(zero_div_r ? 32'd65536 : req.div);
          st_r <= S_MUL3;
        end
        S_MUL3: begin
          // scale by 60 as 64x - 4x
          den_r <= (den_r << 6) - (den_r << 2);
          num_r <= {nk_r, 32'd0};
          rem_r <= '0;
          q_r <= '0;
          big_r <= 1'b0;
          bit_r <= 7'd97;
          st_r <= S_DIV;
        end
        S_DIV: begin
          num_r <= {num_r[96:0], 1'b0};
          if (!trial[68]) begin
            rem_r <= trial;
            if (bit_r >= 7'd32) big_r <= 1'b1;
            else q_r[bit_r[4:0]] <= 1'b1;
          end else begin
            rem_r <= shifted;
          end
          if (bit_r == 7'd0) begin
            st_r <= S_IDLE;
            done_r <= 1'b1;
          end
          bit_r <= bit_r - 7'd1;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign rsp.done = done_r;
  assign rsp.big = big_r;
  assign rsp.frac = q_r;
endmodule

// File: hw/rtl/tempo_phasor_bank_unit.sv
// Tempo phasor bank top level: APB registers, stream ports, phasor walk sequencer.
// Depends on tpb_pkg and tpb_inc_div.
// Tick: the increment unit forms its products, then 98 quotient bits one a cycle; then the walk
// takes one cycle per active phasor, then one per result while the output is not stalled. The
// input is ready again once the last result is taken. Other ops are taken in S_IDLE.
// Synchronous active-low reset: registers to defaults, phases zero, all stopped, one phasor.
module tempo_phasor_bank_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [1:0] op, [6:2] count
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [3:0] index, [35:4] phase, [36] wrapped, [41:37] active_count
  output logic        out_tlast
);
  localparam int N = tpb_pkg::MaxPhasors;
  localparam int IW = tpb_pkg::IdxW;
  localparam int CW = tpb_pkg::CntW;

  typedef enum logic [2:0] {S_IDLE, S_WAIT, S_WALK, S_EMIT} st_t;

  logic [19:0] tempo_r;
  logic [31:0] mult_r, div_r, offset_r;
  logic [29:0] tick_r;
  logic loop_r, multi_r;

  logic [31:0] phase_r [N];
  logic [N-1:0] stop_r;
  logic [N-1:0] wrap_r;
  logic [CW-1:0] active_r, pending_r, rd_r, wr_r, removed_r, emit_r;
  st_t st_r;
  logic start_r;
  logic out_valid_r;
  logic [IW-1:0] oidx_r;
  logic [31:0] ophase_r;
  logic owrap_r, olast_r;
  logic [CW-1:0] ocnt_r;

  tpb_pkg::inc_req_t req;
  tpb_pkg::inc_rsp_t rsp;
  logic [31:0] inc_r;
  logic big_r;

  assign req.start = start_r;
  assign req.tempo = tempo_r;
  assign req.mult = mult_r;
  assign req.div = div_r;
  assign req.tick = tick_r;

  tpb_inc_div u_div (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp));

  logic cfg_wr;
  logic [2:0] cfg_idx;
  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_idx = cfg_paddr[4:2];

  always_comb begin
    case (tpb_pkg::reg_t'(cfg_idx))
      tpb_pkg::REG_TEMPO:  cfg_prdata = 32'(tempo_r);
      tpb_pkg::REG_MULT:   cfg_prdata = mult_r;
      tpb_pkg::REG_DIV:    cfg_prdata = div_r;
      tpb_pkg::REG_TICK:   cfg_prdata = 32'(tick_r);
      tpb_pkg::REG_OFFSET: cfg_prdata = offset_r;
      tpb_pkg::REG_LOOP:   cfg_prdata = 32'(loop_r);
      tpb_pkg::REG_MULTI:  cfg_prdata = 32'(multi_r);
      default:             cfg_prdata = 32'd0;
    endcase
  end

  logic [1:0] op;
  logic [4:0] cnt_in;
  assign op = in_tdata[1:0];
  assign cnt_in = in_tdata[6:2];
  assign in_tready = (st_r == S_IDLE);

  // walk datapath for the current read slot
  logic [IW-1:0] rdi, wri, lasti, acti;
  logic [32:0] sum;
  logic w, stp, rm;
  assign rdi = rd_r[IW-1:0];
  assign wri = wr_r[IW-1:0];
  assign lasti = IW'(active_r - CW'(1));
  assign acti = active_r[IW-1:0];
  assign sum = {1'b0, phase_r[rdi]} + {1'b0, inc_r};
  assign w = big_r | sum[32];
  assign rm = w & ~loop_r & multi_r & (active_r > CW'(1)) & (removed_r < active_r - CW'(1));
  assign stp = loop_r ? 1'b0 : (stop_r[rdi] | w);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tempo_r <= 20'd120000;
      mult_r <= 32'd65536;
      div_r <= 32'd65536;
      tick_r <= 30'd60000;
      offset_r <= 32'd0;
      loop_r <= 1'b1;
      multi_r <= 1'b0;
      for (int i = 0; i < N; i++) phase_r[i] <= 32'd0;
      stop_r <= '1;
      active_r <= CW'(1);
      pending_r <= '0;
      st_r <= S_IDLE;
      start_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      start_r <= 1'b0;
      if (cfg_wr) begin
        case (tpb_pkg::reg_t'(cfg_idx))
          tpb_pkg::REG_TEMPO:  tempo_r <= cfg_pwdata[19:0];
          tpb_pkg::REG_MULT:   mult_r <= cfg_pwdata;
          tpb_pkg::REG_DIV:    div_r <= cfg_pwdata;
          tpb_pkg::REG_TICK:   tick_r <= cfg_pwdata[29:0];
          tpb_pkg::REG_OFFSET: offset_r <= cfg_pwdata;
          tpb_pkg::REG_LOOP:   loop_r <= cfg_pwdata[0];
          tpb_pkg::REG_MULTI:  multi_r <= cfg_pwdata[0];
          default: ;
        endcase
      end
      case (st_r)
        S_IDLE: begin
          if (in_tvalid) begin
            case (tpb_pkg::op_t'(op))
              tpb_pkg::OP_TICK: begin
                if (pending_r != '0) begin
                  for (int i = 0; i < N; i++) begin
                    phase_r[i] <= 32'd0;
                    if (CW'(i) >= active_r && CW'(i) < pending_r) stop_r[i] <= ~loop_r;
                  end
                  active_r <= pending_r;
                  pending_r <= '0;
                end
                start_r <= 1'b1;
                st_r <= S_WAIT;
              end
              tpb_pkg::OP_SET_COUNT: begin
                if (cnt_in != 5'd0)
                  pending_r <= (cnt_in > 5'(N)) ? CW'(N) : CW'(cnt_in);
              end
              default: begin
                if (op == tpb_pkg::OP_LOCAL_TRIG && multi_r) begin
                  if (stop_r[lasti]) begin
                    stop_r[lasti] <= 1'b0;
                  end else if (active_r < CW'(N)) begin
                    phase_r[acti] <= 32'd0;
                    stop_r[acti] <= 1'b0;
                    active_r <= active_r + CW'(1);
                  end else begin
                    phase_r[lasti] <= 32'd0;
                    stop_r[lasti] <= 1'b0;
                  end
                end else if (op == tpb_pkg::OP_LOCAL_TRIG || loop_r) begin
                  for (int i = 0; i < N; i++) phase_r[i] <= 32'd0;
                  stop_r <= '0;
                end
              end
            endcase
          end
        end
        S_WAIT: begin
          if (rsp.done) begin
            inc_r <= rsp.frac;
            big_r <= rsp.big;
            rd_r <= '0;
            wr_r <= '0;
            removed_r <= '0;
            st_r <= S_WALK;
          end
        end
        S_WALK: begin
          // compact in place: write slot never passes read slot
          if (rm) begin
            removed_r <= removed_r + CW'(1);
          end else begin
            phase_r[wri] <= stp ? 32'd0 : sum[31:0];
            stop_r[wri] <= stp;
            wrap_r[wri] <= w;
            wr_r <= wr_r + CW'(1);
          end
          rd_r <= rd_r + CW'(1);
          if (rd_r + CW'(1) == active_r) begin
            active_r <= rm ? wr_r : wr_r + CW'(1);
            emit_r <= '0;
            st_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!out_valid_r || out_tready) begin
            if (emit_r == active_r) begin
              out_valid_r <= 1'b0;
              st_r <= S_IDLE;
            end else begin
              out_valid_r <= 1'b1;
              oidx_r <= emit_r[IW-1:0];
              ophase_r <= phase_r[emit_r[IW-1:0]] + offset_r;
              owrap_r <= wrap_r[emit_r[IW-1:0]];
              olast_r <= (emit_r + CW'(1) == active_r);
              ocnt_r <= active_r;
              emit_r <= emit_r + CW'(1);
            end
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast = olast_r;
  assign out_tdata = {6'd0, 5'(ocnt_r), owrap_r, ophase_r, 4'(oidx_r)};
endmodule

// File: hw/rtl/tpb_checker.sv
// Port-level checker for the tempo phasor bank, bound to the top level.
// Depends on tempo_phasor_bank_unit ports only.
module tpb_checker (
  input logic clk,
  input logic rst_n,
  input logic in_tready,
  input logic out_tvalid,
  input logic out_tready,
  input logic out_tlast,
  input logic [47:0] out_tdata,
  input logic cfg_pready
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped while stalled");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("input ready during result transaction");
  a_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata[3:0] + 5'd1 == out_tdata[41:37])
    else $error("last index mismatch");
  a_pready: assert property (@(posedge clk) cfg_pready)
    else $error("pready low");
endmodule

bind tempo_phasor_bank_unit tpb_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tlast(out_tlast),
  .out_tdata(out_tdata), .cfg_pready(cfg_pready)
);

// File: tb/tb.sv
// Testbench for tempo_phasor_bank_unit: random and directed op streams checked by a scoreboard.
// Scoreboard predicts per-tick phase results; depends on tpb_pkg and the unit RTL.
`timescale 1ns / 1ps

typedef struct {
  bit [3:0]  index;
  bit [31:0] phase;
  bit        wrapped;
  bit        last;
  bit [4:0]  active_count;
} phasor_result_t;

class phasor_scoreboard;
  bit [19:0] tempo;
  bit [31:0] mult, divr, offset;
  bit [29:0] rate;
  bit        loop_on, multi_on;
  bit [31:0] phase[tpb_pkg::MaxPhasors];
  bit        stopped[tpb_pkg::MaxPhasors];
  int        active, pending;
  phasor_result_t awaited[$];
  int        errors;

  function new();
    tempo = 120000; mult = 65536; divr = 65536; rate = 60000;
    offset = 0; loop_on = 1; multi_on = 0;
    foreach (phase[i]) begin
      phase[i] = 0;
      stopped[i] = 1;
    end
    active = 1; pending = 0; errors = 0;
  endfunction

  function void write_reg(tpb_pkg::reg_t r, bit [31:0] v);
    case (r)
      tpb_pkg::REG_TEMPO:  tempo = v[19:0];
      tpb_pkg::REG_MULT:   mult = v;
      tpb_pkg::REG_DIV:    divr = v;
      tpb_pkg::REG_TICK:   rate = v[29:0];
      tpb_pkg::REG_OFFSET: offset = v;
      tpb_pkg::REG_LOOP:   loop_on = v[0];
      tpb_pkg::REG_MULTI:  multi_on = v[0];
      default: ;
    endcase
  endfunction

  // inc = tempo*mult*2^32 / (60*rate*div); a zero divider counts as 0.0001
  function void tempo_increment(output bit [31:0] frac, output bit whole);
    logic [127:0] num, den, q;
    num = tempo;
    num = num * mult;
    den = 60;
    den = den * ((rate == 0) ? 30'd1 : rate);
    if (divr == 0) begin
      num = num * 10000;
      den = den * 65536;
    end else begin
      den = den * divr;
    end
    num = num << 32;
    q = num / den;
    frac = q[31:0];
    whole = q[127:32] != 0;
  endfunction

  function void restart_all();
    foreach (phase[i]) begin
      phase[i] = 0;
      stopped[i] = 0;
    end
  endfunction

  function void note_input(bit [1:0] op, bit [4:0] count);
    bit [31:0] inc, sum;
    bit whole, w;
    bit drop[tpb_pkg::MaxPhasors];
    bit wrap[tpb_pkg::MaxPhasors];
    int removed, n;
    phasor_result_t r;
    removed = 0; n = 0;
    case (op)
      tpb_pkg::OP_LOCAL_TRIG, tpb_pkg::OP_GLOBAL_RST: begin
        if (op == tpb_pkg::OP_LOCAL_TRIG && multi_on) begin
          if (stopped[active-1]) begin
            stopped[active-1] = 0;
          end else if (active < tpb_pkg::MaxPhasors) begin
            phase[active] = 0;
            stopped[active] = 0;
            active++;
          end else begin
            phase[active-1] = 0;
            stopped[active-1] = 0;
          end
        end else if (op == tpb_pkg::OP_LOCAL_TRIG || loop_on) begin
          restart_all();
        end
      end
      tpb_pkg::OP_SET_COUNT: begin
        if (count != 0) pending = (count > tpb_pkg::MaxPhasors) ? tpb_pkg::MaxPhasors : count;
      end
      default: begin
        if (pending > 0) begin
          for (int i = active; i < pending; i++) stopped[i] = !loop_on;
          active = pending;
          foreach (phase[i]) phase[i] = 0;
          pending = 0;
        end
        tempo_increment(inc, whole);
        for (int i = 0; i < active; i++) begin
          sum = phase[i] + inc;
          w = whole || (sum < phase[i]);
          drop[i] = 0;
          wrap[i] = w;
          if (w && !loop_on) begin
            stopped[i] = 1;
            if (multi_on && active > 1 && removed < active - 1) begin
              drop[i] = 1;
              removed++;
            end
          end
          if (loop_on) stopped[i] = 0;
          phase[i] = stopped[i] ? 32'd0 : sum;
        end
        // compact survivors in order
        for (int i = 0; i < active; i++) begin
          if (!drop[i]) begin
            phase[n] = phase[i];
            stopped[n] = stopped[i];
            wrap[n] = wrap[i];
            n++;
          end
        end
        active = n;
        for (int i = 0; i < n; i++) begin
          r.index = 4'(i);
          r.phase = phase[i] + offset;
          r.wrapped = wrap[i];
          r.last = (i + 1 == n);
          r.active_count = 5'(n);
          awaited = {awaited, r};
        end
      end
    endcase
  endfunction

  function void check_result(bit [47:0] data, bit tlast);
    phasor_result_t e;
    if (awaited.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected result: tdata=%h last=%0d", data, tlast);
      return;
    end
    e = awaited.pop_front();
    if (data[3:0] != e.index || data[35:4] != e.phase || data[36] != e.wrapped ||
        tlast != e.last || data[41:37] != e.active_count) begin
      errors++;
      if (errors <= 10)
        $display({"mismatch: exp idx=%0d ph=%h w=%0d l=%0d n=%0d",
                  " got idx=%0d ph=%h w=%0d l=%0d n=%0d"},
                 e.index, e.phase, e.wrapped, e.last, e.active_count,
                 data[3:0], data[35:4], data[36], tlast, data[41:37]);
    end
  endfunction
endclass

module tb;
  logic        clk, rst_n;
  logic        in_tvalid, in_tready;
  logic [7:0]  in_tdata;   // [1:0] op, [6:2] count
  logic        cfg_psel, cfg_penable, cfg_pwrite;
  logic [4:0]  cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;
  logic        cfg_pready;
  logic        out_tvalid, out_tready;
  logic [47:0] out_tdata;  // [3:0] index, [35:4] phase, [36] wrapped, [41:37] active_count
  logic        out_tlast;

  phasor_scoreboard phasors = new();
  int burst_left, hold_off;
  int cycles = 0;

  tempo_phasor_bank_unit DUT (.*);

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 1000000) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk)
    if (rst_n && out_tvalid && out_tready) phasors.check_result(out_tdata, out_tlast);

  // receiver: random stall pattern, plus a long hold-off when requested
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off > 0) begin
        out_tready = 1'b0;
        hold_off--;
      end else if (cycles % 400 < 150) begin
        out_tready = 1'b1;
      end else begin
        out_tready = ($urandom_range(0, 3) != 0);
      end
    end
  end

  task automatic send_op(tpb_pkg::op_t op, bit [4:0] count);
    if (burst_left == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(0, 8)) @(negedge clk);
      burst_left = $urandom_range(1, 10);
    end
    in_tvalid = 1'b1;
    in_tdata = {1'b0, count, op};
    do @(posedge clk); while (!in_tready);
    phasors.note_input(op, count);
    burst_left--;
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  task automatic write_reg(tpb_pkg::reg_t r, bit [31:0] v);
    @(negedge clk);
    cfg_psel = 1'b1; cfg_pwrite = 1'b1; cfg_penable = 1'b0;
    cfg_paddr = {r, 2'b00}; cfg_pwdata = v;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    phasors.write_reg(r, v);
    @(negedge clk);
    cfg_psel = 1'b0; cfg_penable = 1'b0; cfg_pwrite = 1'b0;
  endtask

  task automatic drain();
    while (phasors.awaited.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic random_ops(int n);
    int pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) send_op(tpb_pkg::OP_TICK, 5'($urandom));
      else if (pick < 75) send_op(tpb_pkg::OP_LOCAL_TRIG, 5'($urandom));
      else if (pick < 85) send_op(tpb_pkg::OP_GLOBAL_RST, 5'($urandom));
      else send_op(tpb_pkg::OP_SET_COUNT, 5'($urandom));
    end
  endtask

  initial begin
    rst_n = 1'b0; in_tvalid = 1'b0; in_tdata = '0;
    cfg_psel = 1'b0; cfg_penable = 1'b0; cfg_pwrite = 1'b0;
    cfg_paddr = '0; cfg_pwdata = '0;
    burst_left = 0; hold_off = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: defaults, count saturation and ignore, all ops
    send_op(tpb_pkg::OP_TICK, 5'd0);
    send_op(tpb_pkg::OP_SET_COUNT, 5'd31);
    send_op(tpb_pkg::OP_TICK, 5'd31);
    send_op(tpb_pkg::OP_SET_COUNT, 5'd0);
    send_op(tpb_pkg::OP_TICK, 5'd0);
    send_op(tpb_pkg::OP_LOCAL_TRIG, 5'd0);
    send_op(tpb_pkg::OP_TICK, 5'd0);
    send_op(tpb_pkg::OP_GLOBAL_RST, 5'd0);
    send_op(tpb_pkg::OP_SET_COUNT, 5'd1);
    send_op(tpb_pkg::OP_TICK, 5'd0);
    send_op(tpb_pkg::OP_SET_COUNT, 5'd16);
    send_op(tpb_pkg::OP_SET_COUNT, 5'd5);
    send_op(tpb_pkg::OP_TICK, 5'd0);
    drain();

    // one-shot with multi-trigger, half-cycle increment; long output stall
    write_reg(tpb_pkg::REG_TICK, 32'd4000);
    write_reg(tpb_pkg::REG_LOOP, 32'd0);
    write_reg(tpb_pkg::REG_MULTI, 32'd1);
    send_op(tpb_pkg::OP_LOCAL_TRIG, 5'd0);
    send_op(tpb_pkg::OP_TICK, 5'd0);
    send_op(tpb_pkg::OP_TICK, 5'd0);
    send_op(tpb_pkg::OP_GLOBAL_RST, 5'd0);
    for (int i = 0; i < 17; i++) send_op(tpb_pkg::OP_LOCAL_TRIG, 5'd0);
    hold_off = 1500;
    send_op(tpb_pkg::OP_TICK, 5'd0);
    send_op(tpb_pkg::OP_TICK, 5'd0);
    send_op(tpb_pkg::OP_TICK, 5'd0);
    random_ops(30);
    drain();

    // extremes: whole-cycle increment, zero divider, max offset
    write_reg(tpb_pkg::REG_TEMPO, 32'd1000000);
    write_reg(tpb_pkg::REG_MULT, 32'hFFFF_FFFF);
    write_reg(tpb_pkg::REG_DIV, 32'd0);
    write_reg(tpb_pkg::REG_TICK, 32'd1);
    write_reg(tpb_pkg::REG_OFFSET, 32'hFFFF_FFFF);
    write_reg(tpb_pkg::REG_LOOP, 32'd1);
    write_reg(tpb_pkg::REG_MULTI, 32'd0);
    random_ops(25);
    drain();

    // zero tempo and multiplier, maximum divider, tick rate near its 30-bit limit
    write_reg(tpb_pkg::REG_TEMPO, 32'd0);
    write_reg(tpb_pkg::REG_MULT, 32'd0);
    write_reg(tpb_pkg::REG_DIV, 32'hFFFF_FFFF);
    write_reg(tpb_pkg::REG_TICK, 32'd1000000000);
    write_reg(tpb_pkg::REG_OFFSET, 32'd0);
    random_ops(20);
    drain();

    // random settings, mostly fast enough to wrap now and then
    for (int p = 0; p < 4; p++) begin
      write_reg(tpb_pkg::REG_TEMPO, $urandom_range(0, 1000000));
      write_reg(tpb_pkg::REG_MULT, $urandom_range(0, 32'h0004_0000));
      write_reg(tpb_pkg::REG_DIV, $urandom_range(0, 32'h0004_0000));
      write_reg(tpb_pkg::REG_TICK, $urandom_range(1, 20000));
      write_reg(tpb_pkg::REG_OFFSET, $urandom);
      write_reg(tpb_pkg::REG_LOOP, $urandom_range(0, 1));
      write_reg(tpb_pkg::REG_MULTI, $urandom_range(0, 1));
      random_ops(10);
      drain();
    end

    if (phasors.errors == 0 && phasors.awaited.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

// File: files.f
hw/rtl/tpb_pkg.sv
hw/rtl/tpb_inc_div.sv
hw/rtl/tempo_phasor_bank_unit.sv
hw/rtl/tpb_checker.sv
tb/tb.sv
